FILE: design/rpn_pkg.sv
// Shared command, status and control types for the RPN stack calculator.
`timescale 1ns / 1ps

package rpn_pkg;

  localparam logic [3:0] KIND_PUSH     = 4'd0;
  localparam logic [3:0] KIND_ADD      = 4'd1;
  localparam logic [3:0] KIND_SUB      = 4'd2;
  localparam logic [3:0] KIND_MUL      = 4'd3;
  localparam logic [3:0] KIND_DIV      = 4'd4;
  localparam logic [3:0] KIND_NEG      = 4'd5;
  localparam logic [3:0] KIND_DUP      = 4'd6;
  localparam logic [3:0] KIND_SWAP     = 4'd7;
  localparam logic [3:0] KIND_PRINT    = 4'd8;
  localparam logic [3:0] KIND_CLEAR    = 4'd9;
  localparam logic [3:0] KIND_PRINTALL = 4'd10;

  localparam logic [2:0] ST_SHOWN   = 3'd0;
  localparam logic [2:0] ST_FEW     = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam int unsigned MAX_RESULTS = 32;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_B,
    OP_LOAD_A,
    OP_ALU,
    OP_DIV_START,
    OP_DIV_STEP
  } dp_op_e;

  // Controller-to-datapath command group.
  typedef struct packed {
    dp_op_e     op;
    logic [3:0] kind;
  } dp_cmd_t;

  // Datapath-to-controller status group.
  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

FILE: design/rpn_stack_calculator.sv
// Reverse-Polish Q-format stack calculator: controller, datapath and stack RAM.
// Push, clear and bad codes finish in the idle state; add, sub, mul, negate, swap, dup, print
// step through further states to read operands from the registered-read stack RAM.
// Divide runs the divider over 32+FRAC_BITS quotient bits, one quotient bit per cycle in the divider.
// Print all does one RAM read per shown entry, from the top down; up to 32 beats.
// Reset (async, active low) empties the stack; RAM contents stay undefined.
`timescale 1ns / 1ps

module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  kind_i,
  input  logic signed [31:0] push_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic signed [15:0] shown_value_o,
  output logic        last_of_run_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  rpn_pkg::dp_cmd_t cmd;
  rpn_pkg::dp_sts_t sts;
  logic [31:0]   b_val, res_val, rdata, wdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   sv;

  rpn_ctrl #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i,
    .push_value_i(push_value_i),
    .out_valid_o, .out_stall_i, .status_o, .shown_value_o(sv), .last_of_run_o,
    .cmd_o(cmd), .sts_i(sts), .b_i(b_val), .result_i(res_val), .rdata_i(rdata),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr)
  );

  rpn_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .rdata_i(rdata), .sts_o(sts),
    .b_o(b_val), .result_o(res_val)
  );

  rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign shown_value_o = sv;

endmodule

FILE: design/rpn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/rpn_datapath.sv
// Operand registers, adder, multiplier and restoring divider of the calculator.
`timescale 1ns / 1ps

module rpn_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rpn_pkg::dp_cmd_t cmd_i,
  input  logic [31:0]     rdata_i,
  output rpn_pkg::dp_sts_t sts_o,
  output logic [31:0]     b_o,
  output logic [31:0]     result_o
);

  localparam int unsigned DivW  = 32 + FRAC_BITS;
  localparam int unsigned CntW  = $clog2(DivW + 1);

  logic [31:0]     a_q, b_q, res_q;
  logic [DivW-1:0] quo_q;
  logic [32:0]     rem_q;
  logic [31:0]     den_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;

  logic signed [32:0] add_s, sub_s;
  logic signed [63:0] prod_s, prod_sh;
  logic [31:0]        a_mag, b_mag;
  logic [33:0]        rem_sh;
  logic [33:0]        rem_try;
  logic [DivW-1:0]    quo_n;
  logic [DivW:0]      qsigned;

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    add_s   = $signed({a_q[31], a_q}) + $signed({b_q[31], b_q});
    sub_s   = $signed({a_q[31], a_q}) - $signed({b_q[31], b_q});
    prod_s  = $signed(a_q) * $signed(b_q);
    // Truncate toward zero: bias negative products before the shift.
    prod_sh = (prod_s + ((prod_s < 0) ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0))
              >>> FRAC_BITS;
    a_mag   = a_q[31] ? (~a_q + 32'd1) : a_q;
    b_mag   = b_q[31] ? (~b_q + 32'd1) : b_q;
    rem_sh  = {rem_q, quo_q[DivW-1]};
    rem_try = rem_sh - {2'b00, den_q};
    quo_n   = {quo_q[DivW-2:0], ~rem_try[33]};
    qsigned = neg_q ? (~{1'b0, quo_n} + 1'b1) : {1'b0, quo_n};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.op == rpn_pkg::OP_DIV_START) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivW);
    end else if (cmd_i.op == rpn_pkg::OP_DIV_STEP && busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rpn_pkg::OP_LOAD_B: b_q <= rdata_i;
      rpn_pkg::OP_LOAD_A: a_q <= rdata_i;
      rpn_pkg::OP_ALU: begin
        case (cmd_i.kind)
          rpn_pkg::KIND_ADD: res_q <= sat64(64'(add_s));
          rpn_pkg::KIND_SUB: res_q <= sat64(64'(sub_s));
          rpn_pkg::KIND_MUL: res_q <= sat64(prod_sh);
          rpn_pkg::KIND_NEG: res_q <= sat64(-64'($signed(b_q)));
          default:           res_q <= b_q;
        endcase
      end
      rpn_pkg::OP_DIV_START: begin
        quo_q <= {a_mag, {FRAC_BITS{1'b0}}};
        rem_q <= '0;
        den_q <= b_mag;
        neg_q <= a_q[31] ^ b_q[31];
      end
      rpn_pkg::OP_DIV_STEP: begin
        if (busy_q) begin
          quo_q <= quo_n;
          rem_q <= rem_try[33] ? rem_sh[32:0] : rem_try[32:0];
          if (cnt_q == CntW'(1)) begin
            res_q <= sat64(64'($signed(qsigned)));
          end
        end
      end
      default: ;
    endcase
  end

  assign sts_o.div_done = (cmd_i.op == rpn_pkg::OP_DIV_STEP) && busy_q
                          && (cnt_q == CntW'(1));
  assign b_o      = b_q;
  assign result_o = res_q;

endmodule

FILE: design/rpn_ctrl.sv
// Command sequencer: stack pointer, RAM addressing and result generation.
`timescale 1ns / 1ps

module rpn_ctrl #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [3:0]       kind_i,
  input  logic [31:0]      push_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      shown_value_o,
  output logic             last_of_run_o,
  output rpn_pkg::dp_cmd_t cmd_o,
  input  rpn_pkg::dp_sts_t sts_i,
  input  logic [31:0]      b_i,
  input  logic [31:0]      result_i,
  input  logic [31:0]      rdata_i,
  output logic             we_o,
  output logic [$clog2(STACK_DEPTH)-1:0] waddr_o,
  output logic [31:0]      wdata_o,
  output logic [$clog2(STACK_DEPTH)-1:0] raddr_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MAX_RES = rpn_pkg::MAX_RESULTS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD_B   = 4'd1;
  localparam logic [3:0] S_LD_B   = 4'd2;
  localparam logic [3:0] S_LD_A   = 4'd3;
  localparam logic [3:0] S_EXEC   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_WB     = 4'd6;
  localparam logic [3:0] S_SWAP2  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_PA_RD  = 4'd9;
  localparam logic [3:0] S_PA_OUT = 4'd10;

  logic [3:0]  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [3:0]  kind_q, kind_d;
  logic [CW-1:0] walk_q, walk_d;
  logic [CW-1:0] left_q, left_d;
  logic        ov_q, ov_d;
  logic [2:0]  st_q, st_d;
  logic [15:0] sv_q, sv_d;
  logic        last_q, last_d;

  logic [31:0] ipart;
  logic [31:0] bias;
  logic signed [31:0] q32;
  logic [CW-1:0] top_idx, sec_idx;

  // Integer part of a RAM word, truncated toward zero and saturated to 16 bits.
  always_comb begin
    bias  = (rdata_i[31] && FRAC_BITS > 0) ? 32'((64'd1 << FRAC_BITS) - 64'd1) : 32'd0;
    q32   = $signed(rdata_i + bias) >>> FRAC_BITS;
    ipart = q32;
    if (q32 > 32'sd32767) begin
      ipart = 32'd32767;
    end else if (q32 < -32'sd32768) begin
      ipart = 32'hffff_8000;
    end
  end

  assign top_idx = count_q - 1'b1;
  assign sec_idx = count_q - 2'd2;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    kind_d  = kind_q;
    walk_d  = walk_q;
    left_d  = left_q;
    ov_d    = ov_q;
    st_d    = st_q;
    sv_d    = sv_q;
    last_d  = last_q;
    cmd_o.op   = rpn_pkg::OP_NONE;
    cmd_o.kind = kind_q;
    we_o    = 1'b0;
    waddr_o = top_idx[AW-1:0];
    wdata_o = result_i;
    raddr_o = top_idx[AW-1:0];
    // A pending result beat only holds the input while the receiver stalls it.
    in_stall_o = (state_q != S_IDLE) || (ov_q && out_stall_i);

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          kind_d = kind_i;
          st_d   = rpn_pkg::ST_FEW;
          sv_d   = '0;
          last_d = 1'b1;
          case (kind_i)
            rpn_pkg::KIND_PUSH: begin
              if (count_q >= CW'(STACK_DEPTH)) begin
                st_d = rpn_pkg::ST_FULL;
                ov_d = 1'b1;
              end else begin
                we_o    = 1'b1;
                waddr_o = count_q[AW-1:0];
                wdata_o = push_value_i;
                count_d = count_q + 1'b1;
              end
            end
            rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL,
            rpn_pkg::KIND_SWAP: begin
              if (count_q < CW'(2)) ov_d = 1'b1;
              else state_d = S_RD_B;
            end
            rpn_pkg::KIND_DIV, rpn_pkg::KIND_NEG, rpn_pkg::KIND_PRINT: begin
              if (count_q == '0) ov_d = 1'b1;
              else state_d = S_RD_B;
            end
            rpn_pkg::KIND_DUP: begin
              if (count_q == '0) begin
                ov_d = 1'b1;
              end else if (count_q >= CW'(STACK_DEPTH)) begin
                st_d = rpn_pkg::ST_FULL;
                ov_d = 1'b1;
              end else begin
                state_d = S_RD_B;
              end
            end
            rpn_pkg::KIND_CLEAR: count_d = '0;
            rpn_pkg::KIND_PRINTALL: begin
              if (count_q == '0) begin
                st_d = rpn_pkg::ST_EMPTY;
                ov_d = 1'b1;
              end else begin
                walk_d  = count_q;
                left_d  = (count_q > CW'(MAX_RES)) ? CW'(MAX_RES) : count_q;
                state_d = S_PA_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_B: begin
        raddr_o = top_idx[AW-1:0];
        state_d = S_LD_B;
      end
      S_LD_B: begin
        cmd_o.op = rpn_pkg::OP_LOAD_B;
        raddr_o  = sec_idx[AW-1:0];
        case (kind_q)
          rpn_pkg::KIND_PRINT: begin
            st_d    = rpn_pkg::ST_SHOWN;
            sv_d    = ipart[15:0];
            state_d = S_OUT;
          end
          rpn_pkg::KIND_DUP: begin
            we_o    = 1'b1;
            waddr_o = count_q[AW-1:0];
            wdata_o = rdata_i;
            count_d = count_q + 1'b1;
            state_d = S_IDLE;
          end
          rpn_pkg::KIND_NEG: state_d = S_EXEC;
          rpn_pkg::KIND_DIV: begin
            if (rdata_i == '0) begin
              count_d = count_q - 1'b1;
              st_d    = rpn_pkg::ST_DIVZERO;
              state_d = S_OUT;
            end else if (count_q < CW'(2)) begin
              state_d = S_OUT;
            end else begin
              state_d = S_LD_A;
            end
          end
          default: state_d = S_LD_A;
        endcase
      end
      S_LD_A: begin
        cmd_o.op = rpn_pkg::OP_LOAD_A;
        if (kind_q == rpn_pkg::KIND_SWAP) begin
          we_o    = 1'b1;
          waddr_o = top_idx[AW-1:0];
          wdata_o = rdata_i;
          state_d = S_SWAP2;
        end else if (kind_q == rpn_pkg::KIND_DIV) begin
          state_d = S_EXEC;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_SWAP2: begin
        we_o    = 1'b1;
        waddr_o = sec_idx[AW-1:0];
        wdata_o = b_i;
        state_d = S_IDLE;
      end
      S_EXEC: begin
        if (kind_q == rpn_pkg::KIND_DIV) begin
          cmd_o.op = rpn_pkg::OP_DIV_START;
          state_d  = S_DIV;
        end else begin
          cmd_o.op = rpn_pkg::OP_ALU;
          state_d  = S_WB;
        end
      end
      S_DIV: begin
        cmd_o.op = rpn_pkg::OP_DIV_STEP;
        if (sts_i.div_done) state_d = S_WB;
      end
      S_WB: begin
        we_o = 1'b1;
        if (kind_q == rpn_pkg::KIND_NEG) begin
          waddr_o = top_idx[AW-1:0];
        end else begin
          waddr_o = sec_idx[AW-1:0];
          count_d = count_q - 1'b1;
        end
        state_d = S_IDLE;
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PA_RD: begin
        raddr_o = 32'(walk_q - 1'b1) < 32'(STACK_DEPTH) ? AW'(walk_q - 1'b1) : '0;
        state_d = S_PA_OUT;
      end
      S_PA_OUT: begin
        // Keep the read address so the entry stays on rdata while the beat waits.
        raddr_o = AW'(walk_q - 1'b1);
        if (!ov_q || !out_stall_i) begin
          ov_d   = 1'b1;
          st_d   = rpn_pkg::ST_SHOWN;
          sv_d   = ipart[15:0];
          last_d = (left_q == CW'(1));
          walk_d = walk_q - 1'b1;
          left_d = left_q - 1'b1;
          state_d = (left_q == CW'(1)) ? S_IDLE : S_PA_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    walk_q <= walk_d;
    left_q <= left_d;
    st_q   <= st_d;
    sv_q   <= sv_d;
    last_q <= last_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign shown_value_o = sv_q;
  assign last_of_run_o = last_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH)) else $error("stack count above depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_shown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && st_q != rpn_pkg::ST_SHOWN) |-> (sv_q == '0)) else $error("value on error beat");
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |=> (state_q == S_WB)) else $error("divide done not taken");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the RPN stack calculator.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned FRAC  = 16;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] shown;
    logic               last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] kind_i = '0;
  logic signed [31:0] push_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic signed [15:0] shown_value_o;
  logic last_of_run_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int n_errors = 0;

  logic signed [31:0] calc_stack [DEPTH];
  int unsigned calc_count = 0;
  answer_t answers_due [$];

  rpn_stack_calculator #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FRAC)) dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #400000000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic logic signed [31:0] saturate(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] whole_part(input logic signed [31:0] v);
    logic signed [63:0] q;
    q = 64'(v) / (64'sd1 <<< FRAC);
    if (q > 64'sd32767) return 16'sh7fff;
    if (q < -64'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  function automatic void expect_one(input logic [2:0] st, input logic signed [15:0] v,
                                     input logic lst);
    answer_t a;
    a.status = st;
    a.shown = v;
    a.last = lst;
    answers_due.push_back(a);
  endfunction

  // Predicts the answers for one command and updates the shadow stack.
  function automatic void predict_command(input logic [3:0] k, input logic signed [31:0] pv);
    logic signed [31:0] a, b;
    logic signed [63:0] r;
    int unsigned n;
    case (k)
      rpn_pkg::KIND_PUSH: begin
        if (calc_count >= DEPTH) expect_one(rpn_pkg::ST_FULL, '0, 1'b1);
        else begin
          calc_stack[calc_count] = pv;
          calc_count++;
        end
      end
      rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL, rpn_pkg::KIND_DIV: begin
        if (k == rpn_pkg::KIND_DIV && calc_count >= 1 && calc_stack[calc_count-1] == 0) begin
          calc_count--;
          expect_one(rpn_pkg::ST_DIVZERO, '0, 1'b1);
        end else if (calc_count < 2) expect_one(rpn_pkg::ST_FEW, '0, 1'b1);
        else begin
          b = calc_stack[calc_count-1];
          a = calc_stack[calc_count-2];
          case (k)
            rpn_pkg::KIND_ADD: r = 64'(a) + 64'(b);
            rpn_pkg::KIND_SUB: r = 64'(a) - 64'(b);
            rpn_pkg::KIND_MUL: r = (64'(a) * 64'(b)) / (64'sd1 <<< FRAC);
            default:           r = (64'(a) * (64'sd1 <<< FRAC)) / 64'(b);
          endcase
          calc_count--;
          calc_stack[calc_count-1] = saturate(r);
        end
      end
      rpn_pkg::KIND_NEG: begin
        if (calc_count < 1) expect_one(rpn_pkg::ST_FEW, '0, 1'b1);
        else calc_stack[calc_count-1] = saturate(-64'(calc_stack[calc_count-1]));
      end
      rpn_pkg::KIND_DUP: begin
        if (calc_count < 1) expect_one(rpn_pkg::ST_FEW, '0, 1'b1);
        else if (calc_count >= DEPTH) expect_one(rpn_pkg::ST_FULL, '0, 1'b1);
        else begin
          calc_stack[calc_count] = calc_stack[calc_count-1];
          calc_count++;
        end
      end
      rpn_pkg::KIND_SWAP: begin
        if (calc_count < 2) expect_one(rpn_pkg::ST_FEW, '0, 1'b1);
        else begin
          a = calc_stack[calc_count-1];
          calc_stack[calc_count-1] = calc_stack[calc_count-2];
          calc_stack[calc_count-2] = a;
        end
      end
      rpn_pkg::KIND_PRINT: begin
        if (calc_count < 1) expect_one(rpn_pkg::ST_FEW, '0, 1'b1);
        else expect_one(rpn_pkg::ST_SHOWN, whole_part(calc_stack[calc_count-1]), 1'b1);
      end
      rpn_pkg::KIND_CLEAR: calc_count = 0;
      rpn_pkg::KIND_PRINTALL: begin
        if (calc_count == 0) expect_one(rpn_pkg::ST_EMPTY, '0, 1'b1);
        else begin
          n = (calc_count > rpn_pkg::MAX_RESULTS) ? rpn_pkg::MAX_RESULTS : calc_count;
          for (int unsigned i = 0; i < n; i++)
            expect_one(rpn_pkg::ST_SHOWN, whole_part(calc_stack[calc_count-1-i]),
                       i + 1 == n);
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one command and holds it until the beat is taken.
  task automatic send_command(input logic [3:0] k, input logic signed [31:0] pv = 0);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    push_value_i <= pv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_command(k, pv);
  endtask

  always @(posedge clk_i) begin
    if (hold_recv) out_stall_i <= 1'b1;
    else out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_due.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = answers_due.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (shown_value_o !== want.shown)
          report_mismatch($sformatf("value %0d, expected %0d", shown_value_o, want.shown));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", last_of_run_o, want.last));
      end
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(20)) <<< FRAC;
      4: return -($signed($urandom_range(300000)));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_stack();
    for (int k = rpn_pkg::KIND_ADD; k <= rpn_pkg::KIND_PRINTALL; k++) send_command(k[3:0]);
    send_command(4'd11);
    send_command(4'd15);
    drain();
  endtask

  task automatic test_arithmetic_extremes();
    send_command(rpn_pkg::KIND_PUSH, 32'sh7fffffff);
    send_command(rpn_pkg::KIND_DUP);
    send_command(rpn_pkg::KIND_ADD);
    send_command(rpn_pkg::KIND_PRINT);
    send_command(rpn_pkg::KIND_PUSH, 32'sh80000000);
    send_command(rpn_pkg::KIND_NEG);
    send_command(rpn_pkg::KIND_PUSH, 32'sh80000000);
    send_command(rpn_pkg::KIND_SWAP);
    send_command(rpn_pkg::KIND_SUB);
    send_command(rpn_pkg::KIND_PUSH, 32'sh00030000);
    send_command(rpn_pkg::KIND_MUL);
    send_command(rpn_pkg::KIND_PUSH, 32'sh00000001);
    send_command(rpn_pkg::KIND_DIV);
    send_command(rpn_pkg::KIND_PUSH, 0);
    send_command(rpn_pkg::KIND_DIV);
    send_command(rpn_pkg::KIND_PRINTALL);
    send_command(rpn_pkg::KIND_DIV);
    send_command(rpn_pkg::KIND_PUSH, 0);
    send_command(rpn_pkg::KIND_DIV);
    send_command(rpn_pkg::KIND_PRINTALL);
    drain();
  endtask

  // Fills the stack past full, then prints all while the receiver holds off.
  task automatic test_full_stack();
    send_command(rpn_pkg::KIND_CLEAR);
    for (int i = 0; i < DEPTH; i++) send_command(rpn_pkg::KIND_PUSH, pick_value());
    send_command(rpn_pkg::KIND_PUSH, 32'sh00010000);
    send_command(rpn_pkg::KIND_DUP);
    hold_recv = 1'b1;
    fork
      begin
        repeat (3) send_command(rpn_pkg::KIND_PRINTALL);
        send_command(rpn_pkg::KIND_PRINT);
      end
      begin
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_random_commands(input int count);
    logic [3:0] k;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: k = rpn_pkg::KIND_PUSH;
        3: k = ($urandom_range(3) == 0) ? 4'($urandom_range(11, 15)) : rpn_pkg::KIND_PRINTALL;
        4: k = rpn_pkg::KIND_PRINT;
        default: k = 4'($urandom_range(rpn_pkg::KIND_ADD, rpn_pkg::KIND_SWAP));
      endcase
      if (k == rpn_pkg::KIND_PUSH || $urandom_range(30) != 0) send_command(k, pick_value());
      else send_command(rpn_pkg::KIND_CLEAR);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stack();
    test_arithmetic_extremes();
    test_full_stack();
    test_random_commands(25);
    send_idle_pct = 78;
    test_random_commands(25);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    test_random_commands(25);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    test_random_commands(25);
    if (n_errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: files.f
design/rpn_pkg.sv
design/rpn_ram.sv
design/rpn_datapath.sv
design/rpn_ctrl.sv
design/rpn_stack_calculator.sv
bench/testbench.sv
